// ----- sv/tweo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Three-wheel odometry shared definitions
// Widths, scale constants, the CORDIC arctangent table and the control types
// shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package tweo_pkg;

   // Internal arithmetic widths.
   localparam int COUNT_WIDTH = 32;
   localparam int POS_WIDTH   = 40;
   localparam int FRAC_BITS   = 16;

   // Fixed field widths of the channels and registers.
   localparam int IN_COUNT_W = 32;
   localparam int YAW_W      = 16;
   localparam int HEAD_W     = 32;
   localparam int TICK_W     = 16;
   localparam int TRACK_W    = 12;
   localparam int OFFS_W     = 12;
   localparam int CSR_W      = 16;
   localparam int CSR_IDX_W  = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_TICK  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFS  = 2'd2;

   // Register reset values.
   localparam logic [TICK_W-1:0]  TICK_RESET  = 16'd5971;
   localparam logic [TRACK_W-1:0] TRACK_RESET = 12'd380;
   localparam logic [OFFS_W-1:0]  OFFS_RESET  = 12'd230;

   // Derived datapath widths.
   localparam int DIFF_W    = COUNT_WIDTH + 1;           // d2-d1 and d1+d2
   localparam int NUM_W     = DIFF_W + TICK_W + 1;       // tick*diff, dtheta
   localparam int PDO_W     = DIFF_W + OFFS_W + 1;       // diff*offset
   localparam int DS_W      = PDO_W + 1;                 // d3 + quotient
   localparam int DX_W      = DS_W + TICK_W + 1;         // tick*(d3+q)
   localparam int DIV_STEPS = (NUM_W + 1) / 2;           // two bits a cycle
   localparam int DIV_PAD   = 2 * DIV_STEPS;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // Angle conversion.
   localparam int ANG_W      = 32;
   localparam int YAW_SHIFT  = 16;
   localparam int ANG_PROD_W = ANG_W + FRAC_BITS;
   localparam int HALF_W     = ANG_PROD_W / 2;
   localparam int KRAD_W     = 30;
   localparam int KYAW_W     = 33;
   localparam logic [KRAD_W-1:0] K_RAD = 30'd683565276;
   localparam logic [KYAW_W-1:0] K_YAW = 33'd7818749353;
   localparam int PYAW_W = YAW_W + KYAW_W + 1;

   // CORDIC.
   localparam int CORDIC_STEPS = 16;
   localparam int IDX_W        = 4;
   localparam int CW           = 34;
   localparam int SC_W         = 18;
   localparam int PR_W         = POS_WIDTH + SC_W;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CW-1:0] QUARTER     = 34'sd1073741824;

   function automatic logic [ANG_W-1:0] atan_bam(input logic [IDX_W-1:0] idx);
      logic [ANG_W-1:0] v;
      case (idx)
         4'd0:    v = 32'd536870912;
         4'd1:    v = 32'd316933406;
         4'd2:    v = 32'd167458907;
         4'd3:    v = 32'd85004756;
         4'd4:    v = 32'd42667331;
         4'd5:    v = 32'd21354465;
         4'd6:    v = 32'd10679838;
         4'd7:    v = 32'd5340245;
         4'd8:    v = 32'd2670163;
         4'd9:    v = 32'd1335087;
         4'd10:   v = 32'd667544;
         4'd11:   v = 32'd333772;
         4'd12:   v = 32'd166886;
         4'd13:   v = 32'd83443;
         4'd14:   v = 32'd41722;
         default: v = 32'd20861;
      endcase
      return v;
   endfunction

   // Controller states.
   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_MULT    = 11'b000_0000_0010,
      S_DIVINIT = 11'b000_0000_0100,
      S_DIVIDE  = 11'b000_0000_1000,
      S_SCALE   = 11'b000_0001_0000,
      S_CONV    = 11'b000_0010_0000,
      S_ANGLE   = 11'b000_0100_0000,
      S_CORDIC  = 11'b000_1000_0000,
      S_FINISH  = 11'b001_0000_0000,
      S_ROTATE  = 11'b010_0000_0000,
      S_UPDATE  = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic             idle;
      logic             capture;
      logic             mult;
      logic             div_init;
      logic             div_step;
      logic             scale;
      logic             conv;
      logic             angle;
      logic             cordic_step;
      logic [IDX_W-1:0] cordic_idx;
      logic             finish;
      logic             rotate;
      logic             update;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

// ----- sv/tweo_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry input channel
// One beat carries the mode, three absolute encoder counts and the yaw.
// ----------------------------------------------------------------------------
interface tweo_req_if;
   import tweo_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [IN_COUNT_W-1:0] left_count;
   logic signed [IN_COUNT_W-1:0] right_count;
   logic signed [IN_COUNT_W-1:0] side_count;
   logic signed [YAW_W-1:0]      yaw_centideg;

   modport source (output valid, mode, left_count, right_count, side_count, yaw_centideg,
                   input ready);
   modport sink (input valid, mode, left_count, right_count, side_count, yaw_centideg,
                 output ready);
endinterface
`default_nettype wire

// ----- sv/tweo_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry result channel
// One beat carries the selected frame position, the yaw and the heading.
// ----------------------------------------------------------------------------
interface tweo_rsp_if;
   import tweo_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [POS_WIDTH-1:0] pos_x;
   logic signed [POS_WIDTH-1:0] pos_y;
   logic signed [YAW_W-1:0]     yaw_out;
   logic signed [HEAD_W-1:0]    encoder_heading;

   modport source (output valid, pos_x, pos_y, yaw_out, encoder_heading, input ready);
   modport sink (input valid, pos_x, pos_y, yaw_out, encoder_heading, output ready);
endinterface
`default_nettype wire

// ----- sv/three_wheel_encoder_odometry.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Three-wheel encoder odometry
// Dead reckoning from two parallel wheels and one side wheel, with IMU yaw.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch takes one beat per update: mode, three absolute encoder counts and
//   the yaw in hundredths of a degree. rsp_ch returns one beat per request with
//   the position of the selected frame, the yaw and the encoder heading.
//   The csr_ port writes tick length (index 0), track width (1) and side wheel
//   offset (2) with csr_wr_en; write them only while the block is idle.
// Sequencing:
//   An accepted request beat passes through multiply, divider setup, the two
//   radix-4 dividers by the track width, scaling, conversion, angle select,
//   the shared CORDIC, finish, rotation and update into the output register.
//   A new request is taken once the previous one has reached the output
//   register, so the block works on one update at a time.
// Reset:
//   Synchronous and active high. Encoder history, both frames and the heading
//   clear to zero; the registers return to 5971, 380 and 230.
// Stalls:
//   A result waits in the output register while rsp_ch.ready is low; the next
//   request is still processed and holds in its final step until that
//   register frees.
// ----------------------------------------------------------------------------
module three_wheel_encoder_odometry
   import tweo_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   tweo_req_if.sink                  req_ch,
   tweo_rsp_if.source                rsp_ch,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   tweo_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Arithmetic and state.
   tweo_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
`default_nettype wire

// ----- sv/tweo_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry controller
// Sequences one beat through multiply, divide, CORDIC, rotate and update.
// ----------------------------------------------------------------------------
module tweo_ctrl
   import tweo_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(DIV_STEPS - 1);
   localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);

   // Next state and step counter.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (stat.req_valid) begin
               state_in = S_MULT;
            end
         end
         S_MULT:    state_in = S_DIVINIT;
         S_DIVINIT: begin
            state_in = S_DIVIDE;
            cnt_in   = '0;
         end
         S_DIVIDE: begin
            if (cnt_ff == DIV_LAST) begin
               state_in = S_SCALE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SCALE:   state_in = S_CONV;
         S_CONV:    state_in = S_ANGLE;
         S_ANGLE: begin
            state_in = S_CORDIC;
            cnt_in   = '0;
         end
         S_CORDIC: begin
            if (cnt_ff == CORDIC_LAST) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FINISH:  state_in = S_ROTATE;
         S_ROTATE:  state_in = S_UPDATE;
         S_UPDATE: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Commands to the datapath.
   always_comb begin
      cmd             = '0;
      cmd.idle        = (state_ff == S_IDLE);
      cmd.capture     = (state_ff == S_IDLE) && stat.req_valid;
      cmd.mult        = (state_ff == S_MULT);
      cmd.div_init    = (state_ff == S_DIVINIT);
      cmd.div_step    = (state_ff == S_DIVIDE);
      cmd.scale       = (state_ff == S_SCALE);
      cmd.conv        = (state_ff == S_CONV);
      cmd.angle       = (state_ff == S_ANGLE);
      cmd.cordic_step = (state_ff == S_CORDIC);
      cmd.cordic_idx  = cnt_ff[IDX_W-1:0];
      cmd.finish      = (state_ff == S_FINISH);
      cmd.rotate      = (state_ff == S_ROTATE);
      cmd.update      = (state_ff == S_UPDATE) && stat.out_free;
   end

   // A captured beat always moves on to the multiply step.
   a_capture_to_mult: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == S_MULT))
      else $error("capture did not advance to multiply");

   // The divider runs exactly its step count.
   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVIDE && cnt_ff == DIV_LAST) |=> (state_ff == S_SCALE))
      else $error("divider did not finish on its last step");

   // A result is only written when the output register can take it.
   a_update_free: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> stat.out_free)
      else $error("update issued while output register full");

endmodule
`default_nettype wire

// ----- sv/tweo_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry datapath
// Configuration registers, count deltas, multipliers, two radix-4 dividers,
// a shared CORDIC, the rotation and the frame accumulators.
// ----------------------------------------------------------------------------
module tweo_dp
   import tweo_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   tweo_req_if.sink                  req_ch,
   tweo_rsp_if.source                rsp_ch,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   input  wire cmd_type              cmd,
   output stat_type                  stat
);

   localparam logic signed [NUM_W-1:0] DY_LIM =
      NUM_W'((64'd1 << (POS_WIDTH - 1)) - 64'd1);
   localparam logic signed [DX_W-1:0] DX_LIM =
      DX_W'((64'd1 << (POS_WIDTH - 1)) - 64'd1);
   localparam logic signed [CW-1:0] UNIT_P = CW'(65536);
   localparam logic signed [CW-1:0] UNIT_N = -CW'(65536);

   // One restoring divide step: returns quotient bit over new remainder.
   function automatic logic [TRACK_W:0] div_bit(input logic [TRACK_W-1:0] rem,
                                                input logic nb,
                                                input logic [TRACK_W-1:0] dv);
      logic [TRACK_W:0] t;
      t = {rem, nb};
      if (t >= {1'b0, dv}) begin
         return {1'b1, TRACK_W'(t - {1'b0, dv})};
      end
      return {1'b0, t[TRACK_W-1:0]};
   endfunction

   // Configuration.
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [TRACK_W-1:0] track_ff, track_in;
   logic [OFFS_W-1:0]  offs_ff, offs_in;

   // Encoder history and accumulators.
   logic [COUNT_WIDTH-1:0] prev_l_ff, prev_l_in, prev_r_ff, prev_r_in, prev_s_ff, prev_s_in;
   logic [POS_WIDTH-1:0]   gx_ff, gx_in, gy_ff, gy_in, lx_ff, lx_in, ly_ff, ly_in;
   logic [HEAD_W-1:0]      head_ff, head_in;

   // Per-beat working registers.
   logic                     mode_ff, mode_in;
   logic signed [YAW_W-1:0]  yaw_ff, yaw_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in, sum_ff, sum_in, d3_ff, d3_in;
   logic signed [NUM_W-1:0]  p_td_ff, p_td_in, p_ts_ff, p_ts_in;
   logic signed [PDO_W-1:0]  p_do_ff, p_do_in;
   logic signed [PYAW_W-1:0] p_yaw_ff, p_yaw_in;
   logic [DIV_PAD-1:0]       nq1_ff, nq1_in, nq2_ff, nq2_in;
   logic [TRACK_W-1:0]       r1_ff, r1_in, r2_ff, r2_in, dv_ff, dv_in;
   logic                     s1_ff, s1_in, s2_ff, s2_in;
   logic signed [POS_WIDTH-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [NUM_W-1:0]  dth_ff, dth_in;
   logic signed [DS_W-1:0]   dsum_ff, dsum_in;
   logic signed [DX_W-1:0]   p_dx_ff, p_dx_in;
   logic [HALF_W+KRAD_W-1:0] p_lo_ff, p_lo_in;
   logic [HALF_W-1:0]        p_hi_ff, p_hi_in;
   logic signed [CW-1:0]     cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic                     flip_ff, flip_in;
   logic signed [SC_W-1:0]   cos_ff, cos_in, sin_ff, sin_in;
   logic signed [PR_W-1:0]   p_dxc_ff, p_dxc_in, p_dys_ff, p_dys_in;
   logic signed [PR_W-1:0]   p_dyc_ff, p_dyc_in, p_dxs_ff, p_dxs_in;

   // Output register.
   logic                    out_vld_ff, out_vld_in;
   logic [POS_WIDTH-1:0]    out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic signed [YAW_W-1:0] out_yaw_ff, out_yaw_in;
   logic [HEAD_W-1:0]       out_head_ff, out_head_in;

   // Scratch values.
   logic signed [DIFF_W-1:0]   d1_w, d2_w;
   logic signed [NUM_W-1:0]    dy_half;
   logic [PDO_W-1:0]           mag_do;
   logic [NUM_W-1:0]           mag_td;
   logic [TRACK_W:0]           b1a, b1b, b2a, b2b;
   logic signed [PDO_W-1:0]    q2_w;
   logic [ANG_PROD_W-1:0]      rad_sum;
   logic [ANG_W-1:0]           ang;
   logic signed [CW-1:0]       z0, xs, ys, xr, yr;
   logic [ANG_W-1:0]           at;
   logic [POS_WIDTH-1:0]       ax_new, ay_new, ax_old, ay_old;

   always_comb begin
      tick_in  = tick_ff;
      track_in = track_ff;
      offs_in  = offs_ff;
      prev_l_in = prev_l_ff;  prev_r_in = prev_r_ff;  prev_s_in = prev_s_ff;
      gx_in = gx_ff;  gy_in = gy_ff;  lx_in = lx_ff;  ly_in = ly_ff;
      head_in = head_ff;
      mode_in = mode_ff;  yaw_in = yaw_ff;
      diff_in = diff_ff;  sum_in = sum_ff;  d3_in = d3_ff;
      p_td_in = p_td_ff;  p_ts_in = p_ts_ff;  p_do_in = p_do_ff;  p_yaw_in = p_yaw_ff;
      nq1_in = nq1_ff;  nq2_in = nq2_ff;  r1_in = r1_ff;  r2_in = r2_ff;  dv_in = dv_ff;
      s1_in = s1_ff;  s2_in = s2_ff;
      dx_in = dx_ff;  dy_in = dy_ff;  dth_in = dth_ff;  dsum_in = dsum_ff;
      p_dx_in = p_dx_ff;  p_lo_in = p_lo_ff;  p_hi_in = p_hi_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;  flip_in = flip_ff;
      cos_in = cos_ff;  sin_in = sin_ff;
      p_dxc_in = p_dxc_ff;  p_dys_in = p_dys_ff;  p_dyc_in = p_dyc_ff;  p_dxs_in = p_dxs_ff;
      out_x_in = out_x_ff;  out_y_in = out_y_ff;
      out_yaw_in = out_yaw_ff;  out_head_in = out_head_ff;
      out_vld_in = out_vld_ff && !rsp_ch.ready;

      // Configuration writes; indexes past the list are ignored.
      if (csr_wr_en) begin
         case (csr_index)
            CSR_TICK:  tick_in  = csr_wdata[TICK_W-1:0];
            CSR_TRACK: track_in = csr_wdata[TRACK_W-1:0];
            CSR_OFFS:  offs_in  = csr_wdata[OFFS_W-1:0];
            default:   ;
         endcase
      end

      // Capture: wrapped count deltas and their sum and difference.
      d1_w = DIFF_W'($signed(req_ch.left_count[COUNT_WIDTH-1:0] - prev_l_ff));
      d2_w = DIFF_W'($signed(req_ch.right_count[COUNT_WIDTH-1:0] - prev_r_ff));
      if (cmd.capture) begin
         prev_l_in = req_ch.left_count[COUNT_WIDTH-1:0];
         prev_r_in = req_ch.right_count[COUNT_WIDTH-1:0];
         prev_s_in = req_ch.side_count[COUNT_WIDTH-1:0];
         d3_in     = DIFF_W'($signed(req_ch.side_count[COUNT_WIDTH-1:0] - prev_s_ff));
         diff_in   = d2_w - d1_w;
         sum_in    = d1_w + d2_w;
         mode_in   = req_ch.mode;
         yaw_in    = req_ch.yaw_centideg;
      end

      // Products of the tick length, the offset and the yaw scale.
      if (cmd.mult) begin
         p_td_in  = $signed({1'b0, tick_ff}) * diff_ff;
         p_ts_in  = $signed({1'b0, tick_ff}) * sum_ff;
         p_do_in  = diff_ff * $signed({1'b0, offs_ff});
         p_yaw_in = yaw_ff * $signed({1'b0, K_YAW});
      end

      // Divider setup on magnitudes; halve and clamp the forward step.
      mag_td  = p_td_ff[NUM_W-1] ? NUM_W'(-p_td_ff) : NUM_W'(p_td_ff);
      mag_do  = p_do_ff[PDO_W-1] ? PDO_W'(-p_do_ff) : PDO_W'(p_do_ff);
      dy_half = (p_ts_ff + $signed({{(NUM_W-1){1'b0}}, p_ts_ff[NUM_W-1]})) >>> 1;
      if (cmd.div_init) begin
         nq1_in = DIV_PAD'(mag_td);
         nq2_in = DIV_PAD'(mag_do);
         s1_in  = p_td_ff[NUM_W-1];
         s2_in  = p_do_ff[PDO_W-1];
         r1_in  = '0;
         r2_in  = '0;
         dv_in  = (track_ff == '0) ? TRACK_W'(1) : track_ff;
         if (dy_half > DY_LIM) begin
            dy_in = POS_WIDTH'(DY_LIM);
         end else if (dy_half < -DY_LIM) begin
            dy_in = POS_WIDTH'(-DY_LIM);
         end else begin
            dy_in = POS_WIDTH'(dy_half);
         end
      end

      // Two quotient bits per cycle in each lane.
      b1a = div_bit(r1_ff, nq1_ff[DIV_PAD-1], dv_ff);
      b1b = div_bit(b1a[TRACK_W-1:0], nq1_ff[DIV_PAD-2], dv_ff);
      b2a = div_bit(r2_ff, nq2_ff[DIV_PAD-1], dv_ff);
      b2b = div_bit(b2a[TRACK_W-1:0], nq2_ff[DIV_PAD-2], dv_ff);
      if (cmd.div_step) begin
         nq1_in = {nq1_ff[DIV_PAD-3:0], b1a[TRACK_W], b1b[TRACK_W]};
         nq2_in = {nq2_ff[DIV_PAD-3:0], b2a[TRACK_W], b2b[TRACK_W]};
         r1_in  = b1b[TRACK_W-1:0];
         r2_in  = b2b[TRACK_W-1:0];
      end

      // Signed quotients, truncated toward zero.
      q2_w = s2_ff ? -$signed(nq2_ff[PDO_W-1:0]) : $signed(nq2_ff[PDO_W-1:0]);
      if (cmd.scale) begin
         dth_in  = s1_ff ? -$signed(nq1_ff[NUM_W-1:0]) : $signed(nq1_ff[NUM_W-1:0]);
         dsum_in = DS_W'(d3_ff) + DS_W'(q2_w);
      end

      // Side step product and the heading-to-angle partial products.
      if (cmd.conv) begin
         p_dx_in = $signed({1'b0, tick_ff}) * dsum_ff;
         p_lo_in = dth_ff[HALF_W-1:0] * K_RAD;
         p_hi_in = HALF_W'(dth_ff[ANG_PROD_W-1:HALF_W] * K_RAD);
      end

      // Angle select, side step clamp and CORDIC start with half-turn fold.
      rad_sum = ANG_PROD_W'(p_lo_ff) + {p_hi_ff, {HALF_W{1'b0}}};
      ang     = mode_ff ? rad_sum[ANG_PROD_W-1:FRAC_BITS]
                        : p_yaw_ff[ANG_W+YAW_SHIFT-1:YAW_SHIFT];
      z0      = CW'($signed(ang));
      if (cmd.angle) begin
         if (p_dx_ff > DX_LIM) begin
            dx_in = POS_WIDTH'(DX_LIM);
         end else if (p_dx_ff < -DX_LIM) begin
            dx_in = POS_WIDTH'(-DX_LIM);
         end else begin
            dx_in = POS_WIDTH'(p_dx_ff);
         end
         cx_in = CORDIC_GAIN;
         cy_in = '0;
         if (z0 > QUARTER || z0 < -QUARTER) begin
            cz_in   = CW'($signed(ang ^ {1'b1, {(ANG_W-1){1'b0}}}));
            flip_in = 1'b1;
         end else begin
            cz_in   = z0;
            flip_in = 1'b0;
         end
      end

      // One CORDIC rotation per cycle.
      xs = cy_ff >>> cmd.cordic_idx;
      ys = cx_ff >>> cmd.cordic_idx;
      at = atan_bam(cmd.cordic_idx);
      if (cmd.cordic_step) begin
         if (cz_ff >= 0) begin
            cx_in = cx_ff - xs;
            cy_in = cy_ff + ys;
            cz_in = cz_ff - CW'(at);
         end else begin
            cx_in = cx_ff + xs;
            cy_in = cy_ff - ys;
            cz_in = cz_ff + CW'(at);
         end
      end

      // Round to Q16, clamp to the unit and undo the fold.
      xr = (cx_ff + CW'(8192)) >>> 14;
      yr = (cy_ff + CW'(8192)) >>> 14;
      if (xr > UNIT_P) xr = UNIT_P;
      if (xr < UNIT_N) xr = UNIT_N;
      if (yr > UNIT_P) yr = UNIT_P;
      if (yr < UNIT_N) yr = UNIT_N;
      if (cmd.finish) begin
         cos_in = flip_ff ? SC_W'(-xr) : SC_W'(xr);
         sin_in = flip_ff ? SC_W'(-yr) : SC_W'(yr);
      end

      // Rotation products.
      if (cmd.rotate) begin
         p_dxc_in = dx_ff * cos_ff;
         p_dys_in = dy_ff * sin_ff;
         p_dyc_in = dy_ff * cos_ff;
         p_dxs_in = dx_ff * sin_ff;
      end

      // Accumulate into the selected frame and load the output register.
      ax_old = mode_ff ? lx_ff : gx_ff;
      ay_old = mode_ff ? ly_ff : gy_ff;
      ax_new = ax_old + p_dxc_ff[POS_WIDTH+15:16] + p_dys_ff[POS_WIDTH+15:16];
      ay_new = ay_old + p_dyc_ff[POS_WIDTH+15:16] - p_dxs_ff[POS_WIDTH+15:16];
      if (cmd.update) begin
         if (mode_ff) begin
            lx_in       = ax_new;
            ly_in       = ay_new;
            out_head_in = head_ff;
         end else begin
            gx_in       = ax_new;
            gy_in       = ay_new;
            head_in     = head_ff + dth_ff[HEAD_W-1:0];
            out_head_in = head_ff + dth_ff[HEAD_W-1:0];
         end
         out_x_in   = ax_new;
         out_y_in   = ay_new;
         out_yaw_in = yaw_ff;
         out_vld_in = 1'b1;
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= TICK_RESET;
         track_ff   <= TRACK_RESET;
         offs_ff    <= OFFS_RESET;
         prev_l_ff  <= '0;
         prev_r_ff  <= '0;
         prev_s_ff  <= '0;
         gx_ff      <= '0;
         gy_ff      <= '0;
         lx_ff      <= '0;
         ly_ff      <= '0;
         head_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         tick_ff    <= tick_in;
         track_ff   <= track_in;
         offs_ff    <= offs_in;
         prev_l_ff  <= prev_l_in;
         prev_r_ff  <= prev_r_in;
         prev_s_ff  <= prev_s_in;
         gx_ff      <= gx_in;
         gy_ff      <= gy_in;
         lx_ff      <= lx_in;
         ly_ff      <= ly_in;
         head_ff    <= head_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;   yaw_ff <= yaw_in;
      diff_ff <= diff_in;   sum_ff <= sum_in;   d3_ff <= d3_in;
      p_td_ff <= p_td_in;   p_ts_ff <= p_ts_in; p_do_ff <= p_do_in; p_yaw_ff <= p_yaw_in;
      nq1_ff  <= nq1_in;    nq2_ff <= nq2_in;   r1_ff <= r1_in;     r2_ff <= r2_in;
      dv_ff   <= dv_in;     s1_ff <= s1_in;     s2_ff <= s2_in;
      dx_ff   <= dx_in;     dy_ff <= dy_in;     dth_ff <= dth_in;   dsum_ff <= dsum_in;
      p_dx_ff <= p_dx_in;   p_lo_ff <= p_lo_in; p_hi_ff <= p_hi_in;
      cx_ff   <= cx_in;     cy_ff <= cy_in;     cz_ff <= cz_in;     flip_ff <= flip_in;
      cos_ff  <= cos_in;    sin_ff <= sin_in;
      p_dxc_ff <= p_dxc_in; p_dys_ff <= p_dys_in;
      p_dyc_ff <= p_dyc_in; p_dxs_ff <= p_dxs_in;
      out_x_ff <= out_x_in; out_y_ff <= out_y_in;
      out_yaw_ff <= out_yaw_in; out_head_ff <= out_head_in;
   end

   // Channel and status wiring.
   assign req_ch.ready           = cmd.idle;
   assign rsp_ch.valid           = out_vld_ff;
   assign rsp_ch.pos_x           = $signed(out_x_ff);
   assign rsp_ch.pos_y           = $signed(out_y_ff);
   assign rsp_ch.yaw_out         = out_yaw_ff;
   assign rsp_ch.encoder_heading = $signed(out_head_ff);
   assign stat.req_valid         = req_ch.valid;
   assign stat.out_free          = !out_vld_ff || rsp_ch.ready;

endmodule
`default_nettype wire

// ----- dv/three_wheel_encoder_odometry_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-wheel encoder odometry testbench
// Streams encoder and yaw beats through the block under several register
// settings and checks every result beat against an in-bench fixed-point model
// of the dead-reckoning update, with random idling on both channels.
// ----------------------------------------------------------------------------
module three_wheel_encoder_odometry_test;
   import tweo_pkg::*;

   typedef struct {
      bit                 mode;
      logic signed [31:0] left;
      logic signed [31:0] right;
      logic signed [31:0] side;
      logic signed [15:0] yaw;
   } odo_beat_t;

   typedef struct {
      logic signed [39:0] pos_x;
      logic signed [39:0] pos_y;
      logic signed [15:0] yaw;
      logic signed [31:0] heading;
   } odo_pose_t;

   localparam longint ATAN_STEP [16] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861};
   localparam longint GAIN_Q30   = 652032874;
   localparam longint QUARTER_BA = 1073741824;
   localparam longint CD_SCALE   = 64'sd7818749353;
   localparam longint RAD_SCALE  = 64'sd683565276;
   localparam longint POS_LIM    = (64'sd1 <<< 39) - 1;
   localparam int     SETTLE     = 60;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   tweo_req_if req_bus ();
   tweo_rsp_if rsp_bus ();

   three_wheel_encoder_odometry uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus.sink),
      .rsp_ch    (rsp_bus.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Model state and register copies.
   logic [15:0] tick_reg;
   logic [11:0] track_reg;
   logic [11:0] offset_reg;
   logic signed [31:0] last_left, last_right, last_side;
   logic signed [39:0] glob_x, glob_y, loc_x, loc_y;
   logic [31:0] heading_acc;

   odo_beat_t beat_queue[$];
   odo_pose_t pose_queue[$];
   odo_beat_t cur_beat;
   int  mismatch_count = 0;
   int  results_seen = 0;
   bit  no_idle = 0;
   bit  hold_done = 0;
   int  hold_left = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   logic signed [31:0] gen_left = 0, gen_right = 0, gen_side = 0;

   function automatic longint clamp_unit(input longint v);
      if (v > 65536) return 65536;
      if (v < -65536) return -65536;
      return v;
   endfunction

   function automatic longint sat_pos(input longint v);
      if (v > POS_LIM) return POS_LIM;
      if (v < -POS_LIM) return -POS_LIM;
      return v;
   endfunction

   // Sixteen-step CORDIC on a binary angle, folded into the right half plane.
   function automatic void sin_cos(input logic [31:0] ang, output longint c,
                                   output longint s);
      longint x, y, z, xs, ys;
      logic [31:0] folded;
      bit flip;
      x = GAIN_Q30;
      y = 0;
      flip = 0;
      z = longint'(signed'(ang));
      if (z > QUARTER_BA || z < -QUARTER_BA) begin
         folded = ang + 32'h8000_0000;
         z = longint'(signed'(folded));
         flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
         xs = y >>> i;
         ys = x >>> i;
         if (z >= 0) begin
            x = x - xs; y = y + ys; z = z - ATAN_STEP[i];
         end else begin
            x = x + xs; y = y - ys; z = z + ATAN_STEP[i];
         end
      end
      c = clamp_unit((x + 8192) >>> 14);
      s = clamp_unit((y + 8192) >>> 14);
      if (flip) begin
         c = -c;
         s = -s;
      end
   endfunction

   // Rotates the body increment by the angle and adds it to one frame.
   function automatic void rotate_into(inout logic signed [39:0] ax,
                                       inout logic signed [39:0] ay,
                                       input longint dx, input longint dy,
                                       input logic [31:0] ang);
      longint c, s, nx, ny;
      sin_cos(ang, c, s);
      nx = longint'(ax) + ((dx * c) >>> 16) + ((dy * s) >>> 16);
      ny = longint'(ay) + ((dy * c) >>> 16) - ((dx * s) >>> 16);
      ax = nx[39:0];
      ay = ny[39:0];
   endfunction

   // Dead-reckoning update for one accepted beat.
   function automatic odo_pose_t update_pose(input odo_beat_t b);
      odo_pose_t p;
      logic signed [31:0] w1, w2, w3;
      longint d1, d2, d3, tick, track, diff, dth, dx, dy;
      logic [63:0] prod;
      w1 = b.left - last_left;
      w2 = b.right - last_right;
      w3 = b.side - last_side;
      d1 = w1; d2 = w2; d3 = w3;
      tick = tick_reg;
      track = (track_reg == 0) ? 1 : track_reg;
      diff = d2 - d1;
      dth = (tick * diff) / track;
      dx = sat_pos(tick * (d3 + (diff * longint'(offset_reg)) / track));
      dy = sat_pos((tick * (d1 + d2)) / 2);
      last_left = b.left;
      last_right = b.right;
      last_side = b.side;
      if (b.mode == 1'b0) begin
         prod = longint'(b.yaw) * CD_SCALE;
         rotate_into(glob_x, glob_y, dx, dy, prod[47:16]);
         heading_acc = heading_acc + dth[31:0];
         p.pos_x = glob_x;
         p.pos_y = glob_y;
      end else begin
         prod = dth * RAD_SCALE;
         rotate_into(loc_x, loc_y, dx, dy, prod[47:16]);
         p.pos_x = loc_x;
         p.pos_y = loc_y;
      end
      p.yaw = b.yaw;
      p.heading = heading_acc;
      return p;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Clock.
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Input driver: offers queued beats, holds each until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (beat_queue.size() > 0) begin
            cur_beat <= beat_queue[0];
            req_bus.mode <= beat_queue[0].mode;
            req_bus.left_count <= beat_queue[0].left;
            req_bus.right_count <= beat_queue[0].right;
            req_bus.side_count <= beat_queue[0].side;
            req_bus.yaw_centideg <= beat_queue[0].yaw;
            void'(beat_queue.pop_front());
            req_bus.valid <= 1'b1;
            send_gap = pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Each accepted input beat yields one expected pose.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         pose_queue.push_back(update_pose(cur_beat));
   end

   // Result ready, with one long hold-off so the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && results_seen >= 150) begin
         hold_done = 1;
         hold_left = 600;
         rsp_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap = recv_gap - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         recv_gap = pick_gap();
      end
   end

   // Result checker.
   always @(posedge clock) begin
      odo_pose_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen = results_seen + 1;
         if (pose_queue.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected result beat x=%0d y=%0d", rsp_bus.pos_x,
                        rsp_bus.pos_y);
         end else begin
            want = pose_queue.pop_front();
            if (rsp_bus.pos_x !== want.pos_x || rsp_bus.pos_y !== want.pos_y ||
                rsp_bus.yaw_out !== want.yaw ||
                rsp_bus.encoder_heading !== want.heading) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10) begin
                  $display("ERROR: beat %0d exp x=%0d y=%0d yaw=%0d hd=%0d",
                           results_seen, want.pos_x, want.pos_y, want.yaw,
                           want.heading);
                  $display("       got x=%0d y=%0d yaw=%0d hd=%0d",
                           rsp_bus.pos_x, rsp_bus.pos_y, rsp_bus.yaw_out,
                           rsp_bus.encoder_heading);
               end
            end
         end
      end
   end

   task automatic add_beat(input bit mode, input logic [31:0] l, input logic [31:0] r,
                           input logic [31:0] s, input logic [15:0] yaw);
      odo_beat_t b;
      b.mode = mode; b.left = l; b.right = r; b.side = s; b.yaw = yaw;
      gen_left = l; gen_right = r; gen_side = s;
      beat_queue.push_back(b);
   endtask

   function automatic logic [31:0] step_count(input logic [31:0] v);
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return v + $urandom_range(0, 8000) - 4000;
      if (r < 93) return $urandom();
      return v + ($urandom_range(0, 1) ? 32'h7fff_0000 : 32'h8000_f000) + $urandom_range(0, 65535);
   endfunction

   // Mostly smooth motion, with some jumps and out-of-range yaw.
   task automatic add_random(input int count);
      logic [15:0] yaw;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) != 0) yaw = $urandom_range(0, 36000) - 18000;
         else yaw = $urandom();
         add_beat($urandom_range(0, 1), step_count(gen_left), step_count(gen_right),
                  step_count(gen_side), yaw);
      end
   endtask

   // Waits, checking between edges, for an empty pipeline, then lets all updates settle.
   task automatic wait_idle();
      @(negedge clock);
      while (!(beat_queue.size() == 0 && !req_bus.valid && pose_queue.size() == 0))
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_TICK) tick_reg = data;
      else if (idx == CSR_TRACK) track_reg = data[11:0];
      else if (idx == CSR_OFFS) offset_reg = data[11:0];
   endtask

   task automatic write_all(input logic [15:0] t, input logic [15:0] k, input logic [15:0] o);
      wait_idle();
      write_reg(CSR_TICK, t);
      write_reg(CSR_TRACK, k);
      write_reg(CSR_OFFS, o);
   endtask

   // Stimulus and end of run.
   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.mode = 1'b0;
      req_bus.left_count = '0;
      req_bus.right_count = '0;
      req_bus.side_count = '0;
      req_bus.yaw_centideg = '0;
      rsp_bus.ready = 1'b0;
      tick_reg = TICK_RESET;
      track_reg = TRACK_RESET;
      offset_reg = OFFS_RESET;
      last_left = 0; last_right = 0; last_side = 0;
      glob_x = 0; glob_y = 0; loc_x = 0; loc_y = 0;
      heading_acc = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under reset values: extremes, wraps and both modes.
      add_beat(0, 0, 0, 0, 0);
      add_beat(0, 100, 200, 50, 16'sd18000);
      add_beat(0, 300, 100, -50, -16'sd18000);
      add_beat(1, 1000, 1500, 20, 16'sd9000);
      add_beat(1, 500, 200, 20, -16'sd9000);
      add_beat(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'sd4500);
      add_beat(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -16'sd4500);
      add_beat(1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'sd0);
      add_beat(1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'sd0);
      add_beat(0, 32'hffff_ffff, 32'h0000_0001, 32'h5555_5555, 16'sh7fff);
      add_beat(0, 32'h0000_0001, 32'hffff_ffff, 32'haaaa_aaaa, 16'sh8000);
      add_beat(1, 32'h1234_5678, 32'h8765_4321, 32'h0, 16'shffff);
      add_beat(0, 32'h1234_5678, 32'h8765_4321, 32'h0, 16'sd17999);
      write_all(16'd65535, 16'd1, 16'd4095);
      add_beat(0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'sd100);
      add_beat(1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'sd0);
      add_beat(1, 32'h8000_0100, 32'h7fff_0000, 32'h8000_0000, 16'sd0);
      add_random(250);
      write_all(16'd1, 16'd4095, 16'd0);
      add_beat(1, 0, 0, 0, 0);
      add_beat(1, 1, 32'hffff_ffff, 7, 0);
      add_random(250);
      write_all(16'd40000, 16'd0, 16'd1);
      add_random(250);
      for (int ph = 0; ph < 4; ph++) begin
         write_all($urandom(), $urandom(), $urandom());
         no_idle = (ph == 1);
         add_random(250);
      end
      no_idle = 0;
      write_all(TICK_RESET, TRACK_RESET, OFFS_RESET);
      add_random(75);
      wait_idle();
      if (mismatch_count == 0 && pose_queue.size() == 0) begin
         $display("three_wheel_encoder_odometry_test passed");
      end else begin
         $display("three_wheel_encoder_odometry_test failed");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #20_000_000;
      $display("three_wheel_encoder_odometry_test failed");
      $finish;
   end

endmodule
